/* rtl/chunked_message_receiver_crc32_assert.svh */
// Assertion macros used by the chunked message receiver core.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef CHUNKED_MESSAGE_RECEIVER_CRC32_ASSERT_SVH
`define CHUNKED_MESSAGE_RECEIVER_CRC32_ASSERT_SVH

// A property that must hold at every sampled edge.
`define CMRC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that implies a consequence in the same cycle.
`define CMRC_ASSERT_HOLD(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that implies a consequence in the next cycle.
`define CMRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cmrc_pkg.sv */
// Package for the chunked message receiver: word and result types, status
// codes, frame type codes and CRC-32 constants. No dependencies.
`timescale 1ns / 1ps

package cmrc_pkg;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        write_valid;
		logic [12:0] write_address;
		logic [7:0]  write_data;
	} result_t;

	localparam logic [1:0] ST_MID      = 2'd0;
	localparam logic [1:0] ST_PROGRESS = 2'd1;
	localparam logic [1:0] ST_COMPLETE = 2'd2;
	localparam logic [1:0] ST_ERROR    = 2'd3;

	localparam logic [7:0] KIND_START = 8'd1;
	localparam logic [7:0] KIND_DATA  = 8'd2;
	localparam logic [7:0] KIND_END   = 8'd3;

	// Position of the last byte of a start frame and of the first payload byte.
	localparam logic [7:0] START_LAST_POS = 8'd8;
	localparam logic [7:0] PAYLOAD_POS    = 8'd3;
	localparam int         HDR_BYTES      = 8;

	localparam logic [31:0] CRC_POLY = 32'hedb88320;
	localparam logic [31:0] CRC_INIT = 32'hffffffff;

endpackage

/* rtl/cmrc_in_stage.sv */
// Input register of the chunked message receiver.
// Depends on cmrc_pkg for the word type.
`timescale 1ns / 1ps

module cmrc_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      frame_byte,
	input  logic            frame_end,
	input  logic            take,
	output logic            valid_s1,
	output cmrc_pkg::item_t item_s1
);

	logic accept;

	// A held word leaving this cycle frees the register for the next one.
	assign in_ready = !valid_s1 || take;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.frame_byte <= frame_byte;
			item_s1.frame_end  <= frame_end;
		end
	end

endmodule

/* rtl/cmrc_core.sv */
// Session and frame state of the chunked message receiver, with the
// byte-wide CRC-32 update. Depends on cmrc_pkg and the assertion header.
`timescale 1ns / 1ps
`include "chunked_message_receiver_crc32_assert.svh"

module cmrc_core #(
	parameter int MAX_MESSAGE_BYTES = 8192,
	parameter int MAX_FRAME_BYTES   = 244
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  cmrc_pkg::item_t   item,
	output cmrc_pkg::result_t res
);

	localparam int         LEN_W       = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam logic [7:0] FRAME_LIMIT = 8'(MAX_FRAME_BYTES);
	localparam logic [31:0] MSG_LIMIT  = 32'(MAX_MESSAGE_BYTES);

	logic [LEN_W-1:0] ml_q, ml_d;
	logic [LEN_W-1:0] rc_q, rc_d;
	logic [31:0]      ecrc_q, ecrc_d;
	logic [31:0]      crc_q, crc_d;
	logic [7:0]       pos_q, pos_d;
	logic [7:0]       kind_q, kind_d;
	logic [63:0]      hdr_q, hdr_d;
	logic [15:0]      off_q, off_d;
	logic             inv_q, inv_d;

	logic [7:0]  kind;
	logic [31:0] total;
	logic [31:0] rc_ext;
	logic        wr;
	logic        ok;
	logic [1:0]  status;

	// Reflected CRC-32, one bit per step over the incoming byte.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'h000000, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (cmrc_pkg::CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

	assign rc_ext = 32'(rc_q);

	always_comb begin
		kind   = (pos_q == 8'd0) ? item.frame_byte : kind_q;
		kind_d = kind;
		inv_d  = inv_q | (pos_q >= FRAME_LIMIT);
		hdr_d  = hdr_q;
		off_d  = off_q;
		rc_d   = rc_q;
		crc_d  = crc_q;
		ml_d   = ml_q;
		ecrc_d = ecrc_q;
		pos_d  = (pos_q == 8'hff) ? pos_q : pos_q + 8'd1;
		wr     = 1'b0;
		ok     = 1'b0;
		status = cmrc_pkg::ST_MID;

		if (kind == cmrc_pkg::KIND_START) begin
			for (int k = 0; k < cmrc_pkg::HDR_BYTES; k++) begin
				if (pos_q == 8'(k + 1)) begin
					hdr_d[k*8 +: 8] = item.frame_byte;
				end
			end
		end
		total = hdr_d[31:0];

		if (kind == cmrc_pkg::KIND_DATA) begin
			if (pos_q == 8'd0 && ml_q == '0) begin
				inv_d = 1'b1;
			end
			if (pos_q == 8'd1) begin
				off_d = {8'h00, item.frame_byte};
			end
			if (pos_q == 8'd2) begin
				off_d = {item.frame_byte, off_q[7:0]};
				if (32'(off_d) != rc_ext) begin
					inv_d = 1'b1;
				end
			end
			if (pos_q >= cmrc_pkg::PAYLOAD_POS && !inv_d) begin
				if (rc_q < ml_q) begin
					wr    = 1'b1;
					crc_d = crc_byte(crc_q, item.frame_byte);
					rc_d  = rc_q + LEN_W'(1);
				end else begin
					inv_d = 1'b1;
				end
			end
		end

		if (item.frame_end) begin
			if (inv_d) begin
				ok = 1'b0;
			end else if (kind == cmrc_pkg::KIND_START && pos_q == cmrc_pkg::START_LAST_POS) begin
				// A well-formed start frame restarts the count and CRC even if
				// its length is rejected.
				ecrc_d = hdr_d[63:32];
				rc_d   = '0;
				crc_d  = cmrc_pkg::CRC_INIT;
				if (total != 32'd0 && total <= MSG_LIMIT) begin
					ml_d   = total[LEN_W-1:0];
					status = cmrc_pkg::ST_PROGRESS;
					ok     = 1'b1;
				end
			end else if (ml_q == '0) begin
				ok = 1'b0;
			end else if (kind == cmrc_pkg::KIND_DATA && pos_q >= cmrc_pkg::PAYLOAD_POS) begin
				status = cmrc_pkg::ST_PROGRESS;
				ok     = 1'b1;
			end else if (kind == cmrc_pkg::KIND_END && pos_q == 8'd0 && rc_d == ml_q &&
			             (~crc_d) == ecrc_q) begin
				status = cmrc_pkg::ST_COMPLETE;
				ok     = 1'b1;
			end
			if (!ok) begin
				status = cmrc_pkg::ST_ERROR;
				ml_d   = '0;
				rc_d   = '0;
			end
			pos_d  = 8'd0;
			kind_d = 8'd0;
			hdr_d  = 64'd0;
			off_d  = 16'd0;
			inv_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ml_q   <= '0;
			rc_q   <= '0;
			ecrc_q <= 32'd0;
			crc_q  <= cmrc_pkg::CRC_INIT;
			pos_q  <= 8'd0;
			kind_q <= 8'd0;
			hdr_q  <= 64'd0;
			off_q  <= 16'd0;
			inv_q  <= 1'b0;
		end else if (go) begin
			ml_q   <= ml_d;
			rc_q   <= rc_d;
			ecrc_q <= ecrc_d;
			crc_q  <= crc_d;
			pos_q  <= pos_d;
			kind_q <= kind_d;
			hdr_q  <= hdr_d;
			off_q  <= off_d;
			inv_q  <= inv_d;
		end
	end

	assign res.status        = status;
	assign res.write_valid   = wr;
	assign res.write_address = wr ? rc_ext[12:0] : 13'd0;
	assign res.write_data    = wr ? item.frame_byte : 8'd0;

	`CMRC_ASSERT_ALWAYS(a_count_bound, rc_q <= ml_q, "received count beyond message length")
	`CMRC_ASSERT_HOLD(a_write_status, go && res.write_valid, res.status == cmrc_pkg::ST_MID || res.status == cmrc_pkg::ST_PROGRESS, "payload write in a failing frame")
	`CMRC_ASSERT_NEXT(a_error_clears, go && res.status == cmrc_pkg::ST_ERROR, ml_q == '0 && rc_q == '0, "error left a session open")
	`CMRC_ASSERT_NEXT(a_complete_state, go && res.status == cmrc_pkg::ST_COMPLETE, ml_q != '0 && rc_q == ml_q, "completion without a full message")

endmodule

/* rtl/cmrc_out_stage.sv */
// Result register of the chunked message receiver.
// Depends on cmrc_pkg for the result type.
`timescale 1ns / 1ps

module cmrc_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cmrc_pkg::result_t res,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic              write_valid,
	output logic [12:0]       write_address,
	output logic [7:0]        write_data
);

	logic              out_valid_q;
	cmrc_pkg::result_t res_q;

	// The register can take a new result when empty or when its word leaves.
	assign space = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign write_valid   = res_q.write_valid;
	assign write_address = res_q.write_address;
	assign write_data    = res_q.write_data;

endmodule

/* rtl/chunked_message_receiver_crc32.sv */
// Chunked message receiver: takes one frame byte per word and presents one
// result word per byte, through the input and result registers in turn, at a
// sustained rate of one word per cycle; a word waits only while the result
// register is full and not being drained. The session state, counters and the
// byte-wide CRC-32 update sit between the input register and the result
// register, so each byte's whole effect is settled in the single cycle it
// leaves the input register. There is no clearing pass after reset.
`timescale 1ns / 1ps

module chunked_message_receiver_crc32 #(
	parameter int MAX_MESSAGE_BYTES = 8192,
	parameter int MAX_FRAME_BYTES   = 244
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        write_valid,
	output logic [12:0] write_address,
	output logic [7:0]  write_data
);

	logic              valid_s1;
	cmrc_pkg::item_t   item_s1;
	logic              space;
	logic              take;
	cmrc_pkg::result_t res;

	assign take = valid_s1 && space;

	cmrc_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.take       (take),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	cmrc_core #(
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
		.MAX_FRAME_BYTES   (MAX_FRAME_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (take),
		.item   (item_s1),
		.res    (res)
	);

	cmrc_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (take),
		.res           (res),
		.space         (space),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.write_valid   (write_valid),
		.write_address (write_address),
		.write_data    (write_data)
	);

endmodule

/* bench/testbench.sv */
// Self-checking bench for chunked_message_receiver_crc32: frame bytes in, one
// result word out per byte, checked against an in-bench model of the session.
// Depends on cmrc_pkg and the receiver RTL only.
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_MESSAGE_BYTES = 8192;
	localparam int MAX_FRAME_BYTES   = 244;
	localparam int RANDOM_ITEMS      = 1500;
	localparam int WATCHDOG_LIMIT    = 2000;
	localparam int DRAIN_CYCLES      = 10;
	localparam int REPORT_LIMIT      = 10;

	typedef struct packed {
		cmrc_pkg::item_t word;
		logic            hold;
	} feed_t;

	typedef enum int {
		SC_GOOD, SC_BAD_CRC, SC_BAD_OFFSET, SC_OVERRUN, SC_OVERSIZE, SC_SHORT_DATA,
		SC_EARLY_END, SC_FULL_FRAME, SC_BAD_START_LEN, SC_BAD_LENGTH, SC_BAD_END_LEN,
		SC_NOISE, SC_ORPHAN_DATA, SC_COUNT
	} scenario_t;

	typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  frame_byte = 8'h00;
	logic        frame_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic        write_valid;
	logic [12:0] write_address;
	logic [7:0]  write_data;

	chunked_message_receiver_crc32 #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES),
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.frame_byte(frame_byte),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.write_valid(write_valid),
		.write_address(write_address),
		.write_data(write_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	feed_t             byte_feed[$];
	cmrc_pkg::result_t due_results[$];
	logic [7:0]        msg_buf[$];
	logic [7:0]        frame_buf[$];
	logic              hold_next = 1'b0;
	int                n_total = 0;
	int                n_accepted = 0;
	int                n_checked = 0;
	int                bad_results = 0;
	int                idle_cycles = 0;

	// Receiver session state as the model of the block sees it.
	logic [15:0] sess_len;
	logic [15:0] rcvd_count;
	logic [31:0] want_crc;
	logic [31:0] run_crc;
	logic [7:0]  frm_pos;
	logic [7:0]  frm_kind;
	logic [63:0] hdr_bytes;
	logic [15:0] chunk_ofs;
	logic        frm_bad;

	function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] x;
		x = crc ^ {24'h000000, b};
		for (int i = 0; i < 8; i++)
			x = (x >> 1) ^ (x[0] ? cmrc_pkg::CRC_POLY : 32'h00000000);
		return x;
	endfunction

	function automatic logic [31:0] message_crc();
		logic [31:0] crc;
		crc = cmrc_pkg::CRC_INIT;
		for (int i = 0; i < msg_buf.size(); i++)
			crc = crc_step(crc, msg_buf[i]);
		return ~crc;
	endfunction

	function automatic cmrc_pkg::result_t step_receiver(input logic [7:0] b, input logic last);
		cmrc_pkg::result_t r;
		logic [7:0]        pos;
		logic [7:0]        kind;
		logic [31:0]       total;
		int                flen;
		logic              ok;
		r = '0;
		r.status = cmrc_pkg::ST_MID;
		pos = frm_pos;
		kind = (pos == 8'd0) ? b : frm_kind;
		if (pos == 8'd0)
			frm_kind = b;
		if (int'(pos) >= MAX_FRAME_BYTES)
			frm_bad = 1'b1;
		if (kind == cmrc_pkg::KIND_START && pos >= 8'd1 && pos <= cmrc_pkg::START_LAST_POS)
			hdr_bytes[(int'(pos) - 1) * 8 +: 8] = b;
		if (kind == cmrc_pkg::KIND_DATA) begin
			if (pos == 8'd0 && sess_len == 16'd0)
				frm_bad = 1'b1;
			if (pos == 8'd1)
				chunk_ofs = {8'h00, b};
			if (pos == 8'd2) begin
				chunk_ofs[15:8] = b;
				if (chunk_ofs != rcvd_count)
					frm_bad = 1'b1;
			end
			if (pos >= cmrc_pkg::PAYLOAD_POS && !frm_bad) begin
				if (rcvd_count < sess_len) begin
					r.write_valid = 1'b1;
					r.write_address = rcvd_count[12:0];
					r.write_data = b;
					run_crc = crc_step(run_crc, b);
					rcvd_count = rcvd_count + 16'd1;
				end else begin
					frm_bad = 1'b1;
				end
			end
		end
		if (frm_pos != 8'hFF)
			frm_pos = frm_pos + 8'd1;
		if (last) begin
			flen = int'(pos) + 1;
			ok = 1'b0;
			if (frm_bad) begin
				ok = 1'b0;
			end else if (kind == cmrc_pkg::KIND_START && flen == cmrc_pkg::HDR_BYTES + 1) begin
				total = hdr_bytes[31:0];
				want_crc = hdr_bytes[63:32];
				rcvd_count = 16'd0;
				run_crc = cmrc_pkg::CRC_INIT;
				if (total != 32'd0 && total <= 32'(MAX_MESSAGE_BYTES)) begin
					sess_len = total[15:0];
					r.status = cmrc_pkg::ST_PROGRESS;
					ok = 1'b1;
				end
			end else if (sess_len == 16'd0) begin
				ok = 1'b0;
			end else if (kind == cmrc_pkg::KIND_DATA && flen > 3) begin
				r.status = cmrc_pkg::ST_PROGRESS;
				ok = 1'b1;
			end else if (kind == cmrc_pkg::KIND_END && flen == 1 && rcvd_count == sess_len &&
					~run_crc == want_crc) begin
				r.status = cmrc_pkg::ST_COMPLETE;
				ok = 1'b1;
			end
			if (!ok) begin
				r.status = cmrc_pkg::ST_ERROR;
				sess_len = 16'd0;
				rcvd_count = 16'd0;
			end
			frm_pos = 8'd0;
			frm_kind = 8'd0;
			hdr_bytes = 64'd0;
			chunk_ofs = 16'd0;
			frm_bad = 1'b0;
		end
		return r;
	endfunction

	// Stimulus building: frames are assembled in frame_buf and then queued.
	task automatic push_word(input logic [7:0] b, input logic last);
		feed_t f;
		f.word.frame_byte = b;
		f.word.frame_end = last;
		f.hold = hold_next;
		hold_next = 1'b0;
		byte_feed.push_back(f);
	endtask

	task automatic flush_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			push_word(frame_buf[i], i == frame_buf.size() - 1);
		frame_buf.delete();
	endtask

	task automatic queue_start(input logic [31:0] total, input logic [31:0] crc);
		frame_buf.push_back(cmrc_pkg::KIND_START);
		for (int i = 0; i < 4; i++)
			frame_buf.push_back(total[8 * i +: 8]);
		for (int i = 0; i < 4; i++)
			frame_buf.push_back(crc[8 * i +: 8]);
		flush_frame();
	endtask

	task automatic queue_data(input logic [15:0] offset, input int first, input int count,
			input int extra);
		frame_buf.push_back(cmrc_pkg::KIND_DATA);
		frame_buf.push_back(offset[7:0]);
		frame_buf.push_back(offset[15:8]);
		for (int i = 0; i < count; i++)
			frame_buf.push_back(msg_buf[first + i]);
		for (int i = 0; i < extra; i++)
			frame_buf.push_back(8'($urandom));
		flush_frame();
	endtask

	task automatic queue_random_frame(input logic [7:0] kind, input int n);
		frame_buf.push_back(kind);
		for (int i = 1; i < n; i++)
			frame_buf.push_back(8'($urandom));
		flush_frame();
	endtask

	task automatic fill_message(input int n);
		msg_buf.delete();
		for (int i = 0; i < n; i++)
			msg_buf.push_back(8'($urandom));
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(99, 0);
		if (r < 88)
			return $urandom_range(20, 1);
		if (r < 98)
			return $urandom_range(241, 21);
		return $urandom_range(1000, 242);
	endfunction

	// One session: start, data frames, end, with the flaw that mode asks for.
	task automatic gen_session(input scenario_t mode);
		int          mlen;
		int          cut;
		int          sent;
		int          cap;
		int          chunk;
		int          extra;
		int          k;
		logic        stop;
		logic [31:0] crc;
		logic [15:0] offset;
		case (mode)
			SC_OVERSIZE: mlen = $urandom_range(600, 300);
			SC_FULL_FRAME: mlen = $urandom_range(400, 241);
			SC_EARLY_END: mlen = $urandom_range(40, 2);
			default: mlen = pick_length();
		endcase
		fill_message(mlen);
		crc = message_crc();
		if (mode == SC_BAD_CRC) begin
			k = $urandom_range(31, 0);
			crc[k] = ~crc[k];
		end
		queue_start(32'(mlen), crc);
		cut = (mode == SC_EARLY_END) ? $urandom_range(mlen - 1, 1) : mlen;
		sent = 0;
		stop = 1'b0;
		while (sent < cut && !stop) begin
			cap = MAX_FRAME_BYTES - 3;
			if (cap > cut - sent)
				cap = cut - sent;
			chunk = ($urandom_range(3, 0) != 0 && cap > 16) ? $urandom_range(16, 1) :
				$urandom_range(cap, 1);
			if (mode == SC_FULL_FRAME && sent == 0)
				chunk = MAX_FRAME_BYTES - 3;
			offset = 16'(sent);
			extra = 0;
			if (mode == SC_OVERSIZE) begin
				// Runs past the frame limit and, now and then, past position 255.
				chunk = cap;
				extra = $urandom_range(20, 1);
				stop = 1'b1;
			end
			if (mode == SC_BAD_OFFSET && (sent + chunk >= cut || $urandom_range(2, 0) == 0)) begin
				k = $urandom_range(15, 0);
				offset[k] = ~offset[k];
				stop = 1'b1;
			end
			if (mode == SC_OVERRUN && sent + chunk == cut)
				extra = $urandom_range(4, 1);
			if (mode == SC_SHORT_DATA && (sent + chunk >= cut || $urandom_range(2, 0) == 0)) begin
				queue_random_frame(cmrc_pkg::KIND_DATA, $urandom_range(3, 1));
				stop = 1'b1;
			end else begin
				queue_data(offset, sent, chunk, extra);
				sent += chunk;
			end
		end
		push_word(cmrc_pkg::KIND_END, 1'b1);
		if (mode == SC_GOOD && $urandom_range(3, 0) == 0)
			push_word(cmrc_pkg::KIND_END, 1'b1);
	endtask

	task automatic run_scenario(input scenario_t mode);
		int          n;
		logic [31:0] total;
		if ($urandom_range(29, 0) == 0)
			hold_next = 1'b1;
		case (mode)
			SC_BAD_START_LEN: begin
				n = ($urandom_range(1, 0) == 0) ? $urandom_range(8, 1) : $urandom_range(14, 10);
				queue_random_frame(cmrc_pkg::KIND_START, n);
			end
			SC_BAD_LENGTH: begin
				n = $urandom_range(4, 0);
				case (n)
					0: total = 32'd0;
					1: total = 32'(MAX_MESSAGE_BYTES + 1);
					2: total = 32'hFFFFFFFF;
					3: total = 32'($urandom) | 32'h00010000;
					default: total = 32'(MAX_MESSAGE_BYTES);
				endcase
				queue_start(total, 32'($urandom));
				// The largest legal length opens a session that stays incomplete.
				if (total == 32'(MAX_MESSAGE_BYTES)) begin
					fill_message(4);
					queue_data(16'd0, 0, 4, 0);
					push_word(cmrc_pkg::KIND_END, 1'b1);
				end
			end
			SC_BAD_END_LEN: queue_random_frame(cmrc_pkg::KIND_END, $urandom_range(4, 2));
			SC_NOISE: begin
				n = $urandom_range(10, 1);
				for (int i = 0; i < n; i++)
					push_word(8'($urandom), i == n - 1 || $urandom_range(3, 0) == 0);
			end
			SC_ORPHAN_DATA: begin
				queue_random_frame(8'($urandom_range(255, 4)), 1);
				n = $urandom_range(8, 1);
				fill_message(n);
				queue_data(16'd0, 0, n, 0);
				push_word(cmrc_pkg::KIND_END, 1'b1);
			end
			default: gen_session(mode);
		endcase
	endtask

	task automatic note_mismatch(input string what);
		bad_results++;
		if (bad_results <= REPORT_LIMIT)
			$display("%s", what);
	endtask

	// Sender: bursts of words with random gaps; a word marked hold waits until
	// every result already due has come back.
	always @(posedge clk or negedge arst_n) begin : drive_words
		int    gap_left;
		int    burst_left;
		feed_t nxt;
		logic  go;
		if (!arst_n) begin
			in_valid <= 1'b0;
			frame_byte <= 8'h00;
			frame_end <= 1'b0;
			gap_left = 0;
			burst_left = 0;
			sess_len = 16'd0;
			rcvd_count = 16'd0;
			want_crc = 32'd0;
			run_crc = cmrc_pkg::CRC_INIT;
			frm_pos = 8'd0;
			frm_kind = 8'd0;
			hdr_bytes = 64'd0;
			chunk_ofs = 16'd0;
			frm_bad = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				due_results.push_back(step_receiver(frame_byte, frame_end));
				n_accepted++;
			end
			if (!(in_valid && !in_ready)) begin
				go = 1'b0;
				nxt = '0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (byte_feed.size() > 0 &&
						!(byte_feed[0].hold && due_results.size() != 0)) begin
					nxt = byte_feed.pop_front();
					go = 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(40, 1);
						gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
					end else begin
						burst_left--;
					end
				end
				in_valid <= go;
				if (go) begin
					frame_byte <= nxt.word.frame_byte;
					frame_end <= nxt.word.frame_end;
				end
			end
		end
	end

	// Receiver: compares each accepted result and stalls in changing patterns.
	always @(posedge clk or negedge arst_n) begin : check_results
		int                mode_left;
		int                tick;
		rx_mode_t          mode;
		logic              rdy;
		cmrc_pkg::result_t got;
		cmrc_pkg::result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			mode_left = 0;
			tick = 0;
			mode = RX_ALWAYS;
		end else begin
			if (out_valid && out_ready) begin
				got.status = status;
				got.write_valid = write_valid;
				got.write_address = write_address;
				got.write_data = write_data;
				if (due_results.size() == 0) begin
					note_mismatch($sformatf(
						"result %0d with none due: status %0d wv %0b addr %0d data %02h",
						n_checked, got.status, got.write_valid, got.write_address,
						got.write_data));
				end else begin
					want = due_results.pop_front();
					if (got.status !== want.status || got.write_valid !== want.write_valid ||
							got.write_address !== want.write_address ||
							got.write_data !== want.write_data)
						note_mismatch($sformatf({"result %0d: expected status %0d wv %0b ",
							"addr %0d data %02h, got status %0d wv %0b addr %0d data %02h"},
							n_checked, want.status, want.write_valid, want.write_address,
							want.write_data, got.status, got.write_valid,
							got.write_address, got.write_data));
				end
				n_checked++;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(3, 0));
				mode_left = $urandom_range(200, 32);
			end else begin
				mode_left--;
			end
			tick++;
			case (mode)
				RX_ALWAYS: rdy = 1'b1;
				RX_COIN: rdy = ($urandom_range(1, 0) == 1);
				RX_SPARSE: rdy = ($urandom_range(3, 0) == 0);
				default: rdy = ((tick % 8) < 5);
			endcase
			out_ready <= rdy;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int directed;
		// Short message covering byte extremes, a repeated end after completion,
		// an unknown type, an end with no session and data with no session.
		msg_buf.delete();
		msg_buf.push_back(8'h00);
		msg_buf.push_back(8'hFF);
		queue_start(32'd2, message_crc());
		queue_data(16'd0, 0, 2, 0);
		push_word(cmrc_pkg::KIND_END, 1'b1);
		push_word(cmrc_pkg::KIND_END, 1'b1);
		queue_random_frame(8'hFF, 1);
		push_word(cmrc_pkg::KIND_END, 1'b1);
		queue_data(16'd0, 0, 1, 0);
		directed = byte_feed.size();

		hold_next = 1'b1;
		for (int k = 0; k < int'(SC_COUNT); k++)
			run_scenario(scenario_t'(k));
		while (byte_feed.size() < directed + RANDOM_ITEMS) begin
			if ($urandom_range(99, 0) < 55)
				run_scenario(SC_GOOD);
			else
				run_scenario(scenario_t'($urandom_range(int'(SC_COUNT) - 1, 1)));
		end
		n_total = byte_feed.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (n_accepted < n_total)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_results == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
